// File: rtl/core/rchr_pkg.sv
`timescale 1ns / 1ps
package rchr_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = 4;
  localparam int DUTY_W   = 13;
  localparam int STATE_W  = 16;

  localparam logic [DUTY_W-1:0] FULL_DUTY  = 13'd4096;
  localparam logic [DUTY_W-1:0] HOLD_RESET = 13'd2000;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    DUTY_OFF,
    DUTY_FULL,
    DUTY_HOLD
  } duty_kind_t;

  typedef struct packed {
    logic       write;
    duty_kind_t kind;
    logic       on;
    logic       armed;
    logic       reduced;
  } lane_out_t;

endpackage

// File: rtl/core/rchr_lane.sv
`timescale 1ns / 1ps
module rchr_lane
  import rchr_pkg::*;
(
  input  opcode_t   op,
  input  logic      want,
  input  logic      on,
  input  logic      armed,
  input  logic      reduced,
  output lane_out_t res
);

  always_comb begin
    res.write   = 1'b0;
    res.kind    = DUTY_OFF;
    res.on      = on;
    res.armed   = armed;
    res.reduced = reduced;
    unique case (op)
      OP_SET: begin
        res.on = want;
        if (want != on) begin
          res.write = 1'b1;
          if (want) begin
            res.kind    = DUTY_FULL;
            res.armed   = 1'b0;
            res.reduced = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (on) begin
          if (!armed) begin
            res.armed = 1'b1;
          end else if (!reduced) begin
            // pulled in since the previous tick, drop to hold level
            res.write   = 1'b1;
            res.kind    = DUTY_HOLD;
            res.reduced = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/rchr_merge.sv
`timescale 1ns / 1ps
module rchr_merge
  import rchr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [CHANNELS-1:0]      wr_mask,
  input  duty_kind_t [CHANNELS-1:0] kinds,
  input  logic [DUTY_W-1:0]        hold_sat,
  output logic                     can_load,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_channel,
  output logic [DUTY_W-1:0]        out_duty,
  output logic                     out_last
);

  logic [CHANNELS-1:0]       pend;
  logic [CHANNELS-1:0]       pend_next;
  duty_kind_t [CHANNELS-1:0] kind_q;
  logic [DUTY_W-1:0]         hold_q;

  logic [CHANNELS-1:0] pick;
  logic [CHANNELS-1:0] rest;
  logic [CH_W-1:0]     pick_ch;
  duty_kind_t          pick_kind;
  logic [DUTY_W-1:0]   pick_duty;
  logic                out_free;
  logic                pop;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (|pend) && out_free;
  assign pick     = pend & (~pend + CHANNELS'(1));
  assign rest     = pend & ~pick;
  assign can_load = !(|pend) || (pop && !(|rest));

  always_comb begin
    pick_ch   = '0;
    pick_kind = DUTY_OFF;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pick[i]) begin
        pick_ch   = pick_ch | CH_W'(i);
        pick_kind = duty_kind_t'(pick_kind | kind_q[i]);
      end
    end
  end

  always_comb begin
    unique case (pick_kind)
      DUTY_OFF:  pick_duty = '0;
      DUTY_FULL: pick_duty = FULL_DUTY;
      DUTY_HOLD: pick_duty = hold_q;
      default:   pick_duty = '0;
    endcase
  end

  always_comb begin
    pend_next = pend;
    if (load) begin
      pend_next = wr_mask;
    end else if (pop) begin
      pend_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= pend_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_q <= kinds;
      hold_q <= hold_sat;
    end
    if (pop) begin
      out_channel <= pick_ch;
      out_duty    <= pick_duty;
      out_last    <= !(|rest);
    end
  end

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (pend == '0 || (pop && rest == '0)))
    else $error("new item loaded over pending writes");

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    pop |-> $onehot(pick))
    else $error("write pick is not one-hot");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_duty <= FULL_DUTY)
    else $error("duty above full scale");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && pend == '0))
    else $error("writes pending after reset");
`endif

endmodule

// File: rtl/core/relay_coil_hold_reducer.sv
`timescale 1ns / 1ps
// an item's writes wait in the pending mask, then leave through the write output register
// throughput: one write per cycle while rsp_stall is low;
//   an item with no writes produces no write output
// the next item transfers in the cycle the previous item's last write leaves the queue
// reset (rst, synchronous): relay, armed and reduced masks cleared, hold_duty = 2000
module relay_coil_hold_reducer
  import rchr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                hold_duty_we,
  input  logic [DUTY_W-1:0]   hold_duty_wdata,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                opcode,
  input  logic [STATE_W-1:0]  relay_states,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [CH_W-1:0]     channel,
  output logic [DUTY_W-1:0]   duty,
  output logic                last
);

  logic [DUTY_W-1:0]   hold_duty;
  logic [CHANNELS-1:0] on_mask;
  logic [CHANNELS-1:0] armed_mask;
  logic [CHANNELS-1:0] reduced_mask;

  lane_out_t [CHANNELS-1:0]  lane_res;
  logic [CHANNELS-1:0]       wr_mask;
  duty_kind_t [CHANNELS-1:0] kinds;
  logic [CHANNELS-1:0]       on_next;
  logic [CHANNELS-1:0]       armed_next;
  logic [CHANNELS-1:0]       reduced_next;
  logic [DUTY_W-1:0]         hold_sat;
  logic                      can_load;
  logic                      accept;

  assign req_stall = !can_load;
  assign accept    = req_valid && can_load;
  assign hold_sat  = (hold_duty > FULL_DUTY) ? FULL_DUTY : hold_duty;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    rchr_lane u_lane (
      .op      (opcode_t'(opcode)),
      .want    (relay_states[i]),
      .on      (on_mask[i]),
      .armed   (armed_mask[i]),
      .reduced (reduced_mask[i]),
      .res     (lane_res[i])
    );
    assign wr_mask[i]      = lane_res[i].write;
    assign kinds[i]        = lane_res[i].kind;
    assign on_next[i]      = lane_res[i].on;
    assign armed_next[i]   = lane_res[i].armed;
    assign reduced_next[i] = lane_res[i].reduced;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_duty    <= HOLD_RESET;
      on_mask      <= '0;
      armed_mask   <= '0;
      reduced_mask <= '0;
    end else begin
      if (hold_duty_we) begin
        hold_duty <= hold_duty_wdata;
      end
      if (accept) begin
        on_mask      <= on_next;
        armed_mask   <= armed_next;
        reduced_mask <= reduced_next;
      end
    end
  end

  rchr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .wr_mask     (wr_mask),
    .kinds       (kinds),
    .hold_sat    (hold_sat),
    .can_load    (can_load),
    .out_valid   (rsp_valid),
    .out_stall   (rsp_stall),
    .out_channel (channel),
    .out_duty    (duty),
    .out_last    (last)
  );

`ifndef SYNTH
  a_reduced_armed: assert property (@(posedge clk) disable iff (rst)
    (reduced_mask & ~armed_mask) == '0)
    else $error("channel reduced without being armed");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(accept) && !$past(rst) |-> $stable(on_mask) && $stable(armed_mask))
    else $error("relay state changed without a transfer");

  a_off_no_write: assert property (@(posedge clk) disable iff (rst)
    accept && opcode_t'(opcode) == OP_TICK |-> (wr_mask & ~on_mask) == '0)
    else $error("tick writes an off channel");
`endif

endmodule
